/* hdl/pdfp_pkg.sv */
// ----------------------------------------------------------------------------
// pdfp_pkg
// Shared widths, constants and types of the pulldown duplicate frame picker.
// ----------------------------------------------------------------------------
package pdfp_pkg;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int SUM_W   = 31;
   localparam int SLOT_W  = 3;
   localparam int GROUP_W = 24;
   localparam int FRAME_W = 25;

   // byte pairs carried by one request
   localparam int INPUT_LANES = 4;

   // defaults of the top level parameters
   localparam int DEFAULT_GROUP_FRAMES = 5;
   localparam int DEFAULT_LANES        = 4;

   // saturation value of a frame sum, also the empty group best
   localparam logic [SUM_W-1:0] SUM_MAX = 31'h7fff_ffff;

   // frame kind codes
   typedef enum logic [1:0] {
      KIND_COMPARE  = 2'd0,
      KIND_SKIP     = 2'd1,
      KIND_PAST_END = 2'd2,
      KIND_UNUSED   = 2'd3
   } frame_kind_type;

   // control that travels beside the lane differences
   typedef struct packed {
      logic                 valid;
      logic                 frame_end;
      frame_kind_type       kind;
      logic [GROUP_W-1:0]   group_start;
   } lane_ctrl_type;

   // finished frame handed from the accumulator to the picker
   typedef struct packed {
      logic                 valid;
      logic                 offer;
      logic [SUM_W-1:0]     cand;
      logic [GROUP_W-1:0]   group_start;
   } frame_result_type;

endpackage

/* hdl/pdfp_if.sv */
// ----------------------------------------------------------------------------
// pdfp_if
// Request and response channels of the pulldown duplicate frame picker.
// ----------------------------------------------------------------------------
interface pdfp_req_if
   import pdfp_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    prev_byte0;
   logic [BYTE_W-1:0]    prev_byte1;
   logic [BYTE_W-1:0]    prev_byte2;
   logic [BYTE_W-1:0]    prev_byte3;
   logic [BYTE_W-1:0]    cur_byte0;
   logic [BYTE_W-1:0]    cur_byte1;
   logic [BYTE_W-1:0]    cur_byte2;
   logic [BYTE_W-1:0]    cur_byte3;
   logic                 frame_end;
   logic [1:0]           frame_kind;
   logic [GROUP_W-1:0]   group_start;

   modport source (
      output valid, prev_byte0, prev_byte1, prev_byte2, prev_byte3,
             cur_byte0, cur_byte1, cur_byte2, cur_byte3,
             frame_end, frame_kind, group_start,
      input  ready
   );

   modport sink (
      input  valid, prev_byte0, prev_byte1, prev_byte2, prev_byte3,
             cur_byte0, cur_byte1, cur_byte2, cur_byte3,
             frame_end, frame_kind, group_start,
      output ready
   );
endinterface

interface pdfp_rsp_if
   import pdfp_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [FRAME_W-1:0]   drop_frame;
   logic [SLOT_W-1:0]    drop_slot;
   logic [SUM_W-1:0]     drop_difference;

   modport source (
      output valid, drop_frame, drop_slot, drop_difference,
      input  ready
   );

   modport sink (
      input  valid, drop_frame, drop_slot, drop_difference,
      output ready
   );
endinterface

/* hdl/pulldown_duplicate_frame_picker_core.sv */
// Responses come through the lane, accumulator result and response registers.
// Throughput: one request per cycle unless held; the difference lanes (up to
// four), the accumulator and the group picker are each one register stage.
// The pipeline holds only when a group completes while the response register
// still holds an untaken response.
// Reset (synchronous) clears the frame sum, the group best and response valid.
// ----------------------------------------------------------------------------
// pulldown_duplicate_frame_picker_core
// Sums absolute field differences per frame and picks the duplicate frame
// to drop from each group.
// ----------------------------------------------------------------------------
module pulldown_duplicate_frame_picker_core
   import pdfp_pkg::*;
#(
   parameter int GROUP_FRAMES = DEFAULT_GROUP_FRAMES,
   parameter int LANES        = DEFAULT_LANES
)
(
   input  logic        clock,
   input  logic        reset,
   pdfp_req_if.sink    req_ch,
   pdfp_rsp_if.source  rsp_ch
);

   localparam int LanesUsed = (LANES < INPUT_LANES) ? LANES : INPUT_LANES;

   logic [BYTE_W-1:0]   prev_bytes [INPUT_LANES];
   logic [BYTE_W-1:0]   cur_bytes  [INPUT_LANES];
   logic [BYTE_W-1:0]   lane_diff  [LanesUsed];
   lane_ctrl_type       a_ctrl_ff, a_ctrl_in;
   frame_result_type    frame_result;
   logic                emit;
   logic                rsp_valid;
   logic                advance;

   // pipeline moves unless a finished group meets a full response register
   assign advance      = !(emit && rsp_valid && !rsp_ch.ready);
   assign req_ch.ready = advance;

   assign prev_bytes[0] = req_ch.prev_byte0;
   assign prev_bytes[1] = req_ch.prev_byte1;
   assign prev_bytes[2] = req_ch.prev_byte2;
   assign prev_bytes[3] = req_ch.prev_byte3;
   assign cur_bytes[0]  = req_ch.cur_byte0;
   assign cur_bytes[1]  = req_ch.cur_byte1;
   assign cur_bytes[2]  = req_ch.cur_byte2;
   assign cur_bytes[3]  = req_ch.cur_byte3;

   // difference lanes
   for (genvar g = 0; g < LanesUsed; g++) begin : g_lane
      pdfp_lane u_lane (
         .clock     (clock),
         .advance   (advance),
         .prev_byte (prev_bytes[g]),
         .cur_byte  (cur_bytes[g]),
         .diff_ff   (lane_diff[g])
      );
   end

   // request control beside the lanes
   always_comb begin
      a_ctrl_in.valid       = req_ch.valid;
      a_ctrl_in.frame_end   = req_ch.frame_end;
      a_ctrl_in.kind        = frame_kind_type'(req_ch.frame_kind);
      a_ctrl_in.group_start = req_ch.group_start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
      end else if (advance) begin
         a_ctrl_ff <= a_ctrl_in;
      end
   end

   // lane merge and frame sum
   pdfp_merge #(
      .LANES_USED (LanesUsed)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctrl      (a_ctrl_ff),
      .lane_diff (lane_diff),
      .result_ff (frame_result)
   );

   // group minimum and response register
   pdfp_picker #(
      .GROUP_FRAMES (GROUP_FRAMES)
   ) u_picker (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .result          (frame_result),
      .rsp_ready       (rsp_ch.ready),
      .emit            (emit),
      .rsp_valid_ff    (rsp_valid),
      .drop_frame      (rsp_ch.drop_frame),
      .drop_slot       (rsp_ch.drop_slot),
      .drop_difference (rsp_ch.drop_difference)
   );

   assign rsp_ch.valid = rsp_valid;

endmodule

/* hdl/pdfp_lane.sv */
// ----------------------------------------------------------------------------
// pdfp_lane
// One absolute difference lane: |prev - cur| of a byte pair, registered.
// ----------------------------------------------------------------------------
module pdfp_lane
   import pdfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 advance,
   input  logic [BYTE_W-1:0]    prev_byte,
   input  logic [BYTE_W-1:0]    cur_byte,
   output logic [BYTE_W-1:0]    diff_ff
);

   logic [BYTE_W-1:0] diff_in;

   // absolute difference of the pair
   always_comb begin
      if (prev_byte > cur_byte) begin
         diff_in = prev_byte - cur_byte;
      end else begin
         diff_in = cur_byte - prev_byte;
      end
   end

   // lane register, moves with the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff <= diff_in;
      end
   end

endmodule

/* hdl/pdfp_merge.sv */
// ----------------------------------------------------------------------------
// pdfp_merge
// Merges the lane differences and keeps the saturating frame sum.
// ----------------------------------------------------------------------------
module pdfp_merge
   import pdfp_pkg::*;
#(
   parameter int LANES_USED = DEFAULT_LANES
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  lane_ctrl_type        ctrl,
   input  logic [BYTE_W-1:0]    lane_diff [LANES_USED],
   output frame_result_type     result_ff
);

   localparam int AddW = BYTE_W + $clog2(LANES_USED);

   logic [AddW-1:0]     add_sum;
   logic [SUM_W:0]      total;
   logic [SUM_W-1:0]    sat_sum;
   logic [SUM_W-1:0]    frame_sum;
   logic [SUM_W-1:0]    running_ff;
   logic [SUM_W-1:0]    running_in;
   frame_result_type    result_in;

   // merge the lanes into one increment
   always_comb begin
      add_sum = '0;
      for (int i = 0; i < LANES_USED; i++) begin
         add_sum = add_sum + AddW'(lane_diff[i]);
      end
   end

   // saturating accumulate
   always_comb begin
      total = {1'b0, running_ff} + (SUM_W + 1)'(add_sum);
      if (total > {1'b0, SUM_MAX}) begin
         sat_sum = SUM_MAX;
      end else begin
         sat_sum = total[SUM_W-1:0];
      end
      if (ctrl.kind == KIND_COMPARE) begin
         frame_sum = sat_sum;
      end else begin
         frame_sum = running_ff;
      end
   end

   // next running sum and finished frame
   always_comb begin
      running_in = running_ff;
      if (ctrl.valid) begin
         if (ctrl.frame_end) begin
            running_in = '0;
         end else begin
            running_in = frame_sum;
         end
      end
      result_in.valid       = ctrl.valid && ctrl.frame_end;
      result_in.offer       = (ctrl.kind == KIND_COMPARE) || (ctrl.kind == KIND_PAST_END);
      result_in.cand        = (ctrl.kind == KIND_COMPARE) ? frame_sum : '0;
      result_in.group_start = ctrl.group_start;
   end

   // accumulator and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         result_ff  <= '0;
      end else if (advance) begin
         running_ff <= running_in;
         result_ff  <= result_in;
      end
   end

endmodule

/* hdl/pdfp_picker.sv */
// ----------------------------------------------------------------------------
// pdfp_picker
// Keeps the smallest frame sum of a group and holds the response register.
// ----------------------------------------------------------------------------
module pdfp_picker
   import pdfp_pkg::*;
#(
   parameter int GROUP_FRAMES = DEFAULT_GROUP_FRAMES
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  frame_result_type     result,
   input  logic                 rsp_ready,
   output logic                 emit,
   output logic                 rsp_valid_ff,
   output logic [FRAME_W-1:0]   drop_frame,
   output logic [SLOT_W-1:0]    drop_slot,
   output logic [SUM_W-1:0]     drop_difference
);

   localparam logic [SLOT_W:0]   GroupLimit = (SLOT_W + 1)'(GROUP_FRAMES);
   localparam logic [SLOT_W-1:0] LastSlot   = SLOT_W'(GROUP_FRAMES - 1);

   logic [SUM_W-1:0]    best_ff, best_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   count_ff, count_in;
   logic                rsp_valid_in;
   logic [GROUP_W-1:0]  out_group_ff, out_group_in;
   logic [SLOT_W-1:0]   out_slot_ff, out_slot_in;
   logic [SUM_W-1:0]    out_sum_ff, out_sum_in;

   logic [SLOT_W-1:0]   count_next;
   logic                wrap;
   logic                win;
   logic [SUM_W-1:0]    best_upd;
   logic [SLOT_W-1:0]   slot_upd;
   logic                take;

   // candidate compare, strictly smaller wins so ties keep the earlier frame
   always_comb begin
      count_next = count_ff + 1'b1;
      wrap       = ({1'b0, count_next} >= GroupLimit) || (count_next == '0);
      win        = result.offer && (result.cand < best_ff);
      best_upd   = win ? result.cand : best_ff;
      slot_upd   = win ? count_ff : slot_ff;
      emit       = result.valid && wrap;
      take       = result.valid && advance;
   end

   // group state next values
   always_comb begin
      best_in  = best_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      if (take) begin
         if (wrap) begin
            best_in  = SUM_MAX;
            slot_in  = LastSlot;
            count_in = '0;
         end else begin
            best_in  = best_upd;
            slot_in  = slot_upd;
            count_in = count_next;
         end
      end
   end

   // response register next values
   always_comb begin
      out_group_in = out_group_ff;
      out_slot_in  = out_slot_ff;
      out_sum_in   = out_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take && wrap) begin
         out_group_in = result.group_start;
         out_slot_in  = slot_upd;
         out_sum_in   = best_upd;
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= SUM_MAX;
         slot_ff      <= LastSlot;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_ff      <= best_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      out_group_ff <= out_group_in;
      out_slot_ff  <= out_slot_in;
      out_sum_ff   <= out_sum_in;
   end

   // frame number of the dropped frame
   assign drop_frame      = FRAME_W'(out_group_ff) + FRAME_W'(out_slot_ff);
   assign drop_slot       = out_slot_ff;
   assign drop_difference = out_sum_ff;

endmodule

/* hdl/pdfp_checker.sv */
// ----------------------------------------------------------------------------
// pdfp_checker
// Port level checks of the pulldown duplicate frame picker.
// ----------------------------------------------------------------------------
module pdfp_checker
   import pdfp_pkg::*;
#(
   parameter int GROUP_FRAMES = DEFAULT_GROUP_FRAMES
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [FRAME_W-1:0]   drop_frame,
   input  logic [SLOT_W-1:0]    drop_slot,
   input  logic [SUM_W-1:0]     drop_difference
);

   localparam logic [SLOT_W:0]   GroupLimit = (SLOT_W + 1)'(GROUP_FRAMES);
   localparam logic [SLOT_W-1:0] LastSlot   = SLOT_W'(GROUP_FRAMES - 1);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(drop_frame)
         && $stable(drop_slot) && $stable(drop_difference))
      else $error("stalled response changed");

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the chosen slot lies inside the group
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, drop_slot} < GroupLimit))
      else $error("drop slot outside group");

   // a saturated difference only comes with the default last frame
   a_default_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (drop_difference == SUM_MAX) |-> (drop_slot == LastSlot))
      else $error("saturated difference on a non-default slot");

endmodule

bind pulldown_duplicate_frame_picker_core pdfp_checker #(
   .GROUP_FRAMES (GROUP_FRAMES)
) u_pdfp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .drop_frame      (rsp_ch.drop_frame),
   .drop_slot       (rsp_ch.drop_slot),
   .drop_difference (rsp_ch.drop_difference)
);

/* tb/sv/tb_pulldown_duplicate_frame_picker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulldown_duplicate_frame_picker_core
// Streams field byte pairs frame by frame, in groups of five, into the
// duplicate frame picker. A cycle-level predictor runs the per-frame
// difference sums and the group minimum on every accepted request, and each
// drop response is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_pulldown_duplicate_frame_picker_core;
   import pdfp_pkg::*;

   localparam int GROUP_FRAMES = DEFAULT_GROUP_FRAMES;
   localparam int LANES        = DEFAULT_LANES;
   localparam int RANDOM_REQUESTS = 1050;

   // one request as the driver presents it
   typedef struct packed {
      logic [INPUT_LANES-1:0][BYTE_W-1:0] prev;
      logic [INPUT_LANES-1:0][BYTE_W-1:0] cur;
      logic                               frame_end;
      frame_kind_type                     kind;
      logic [GROUP_W-1:0]                 group_start;
   } frame_request_type;

   // one predicted drop decision
   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [SLOT_W-1:0]  slot;
      logic [SUM_W-1:0]   difference;
   } drop_choice_type;

   logic clock;
   logic reset;

   pdfp_req_if req_ch ();
   pdfp_rsp_if rsp_ch ();

   pulldown_duplicate_frame_picker_core #(
      .GROUP_FRAMES (GROUP_FRAMES),
      .LANES        (LANES)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   frame_request_type pending_requests[$];
   drop_choice_type   expected_drops[$];
   frame_request_type next_request;
   frame_request_type seen_request;
   drop_choice_type   want;

   // predictor state
   logic [SUM_W-1:0]  frame_sum;
   logic [SUM_W-1:0]  group_best_sum;
   logic [SLOT_W-1:0] group_best_slot;
   logic [SLOT_W-1:0] frames_in_group;

   int   mismatch_count = 0;
   int   sent_count = 0;
   int   queued_count = 0;
   logic request_taken = 1'b0;
   logic calm;

   // a stretch of requests with neither side idling
   assign calm = (sent_count >= 400) && (sent_count < 650);

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic clear_group_best();
      group_best_sum  = SUM_MAX;
      group_best_slot = SLOT_W'(GROUP_FRAMES - 1);
      frames_in_group = '0;
   endtask

   // frame sum, group minimum and drop decision for one accepted request
   task automatic predict_drop(input frame_request_type rq);
      logic [31:0]      lane_sum;
      logic [31:0]      p;
      logic [31:0]      c;
      logic [SUM_W-1:0] offer;
      drop_choice_type  choice;
      if (rq.kind == KIND_COMPARE) begin
         lane_sum = '0;
         for (int k = 0; k < LANES && k < INPUT_LANES; k++) begin
            p = 32'(rq.prev[k]);
            c = 32'(rq.cur[k]);
            lane_sum += (p > c) ? (p - c) : (c - p);
         end
         // saturate at the all-ones sum
         if (32'(frame_sum) > 32'(SUM_MAX) - lane_sum)
            frame_sum = SUM_MAX;
         else
            frame_sum = frame_sum + lane_sum[SUM_W-1:0];
      end
      if (rq.frame_end) begin
         // kind on the closing request decides candidacy
         if (rq.kind == KIND_COMPARE || rq.kind == KIND_PAST_END) begin
            offer = (rq.kind == KIND_COMPARE) ? frame_sum : '0;
            if (offer < group_best_sum) begin
               group_best_sum  = offer;
               group_best_slot = frames_in_group;
            end
         end
         frame_sum       = '0;
         frames_in_group = frames_in_group + 1'b1;
         if (frames_in_group >= GROUP_FRAMES || frames_in_group == 0) begin
            choice.frame      = FRAME_W'(rq.group_start) + FRAME_W'(group_best_slot);
            choice.slot       = group_best_slot;
            choice.difference = group_best_sum;
            expected_drops.push_back(choice);
            clear_group_best();
         end
      end
   endtask

   task automatic push_request(input logic [31:0] prev, input logic [31:0] cur,
                               input logic frame_end, input frame_kind_type kind,
                               input logic [GROUP_W-1:0] group);
      frame_request_type rq;
      rq.prev        = prev;
      rq.cur         = cur;
      rq.frame_end   = frame_end;
      rq.kind        = kind;
      rq.group_start = group;
      pending_requests.push_back(rq);
      queued_count++;
   endtask

   // spread 0: identical bytes, 1: near bytes, 2: unrelated bytes
   task automatic push_random_request(input logic frame_end, input frame_kind_type kind,
                                      input logic [GROUP_W-1:0] group, input int spread);
      logic [31:0] prev;
      logic [31:0] cur;
      for (int k = 0; k < INPUT_LANES; k++) begin
         prev[k*8 +: 8] = 8'($urandom_range(255));
         case (spread)
            0: cur[k*8 +: 8] = prev[k*8 +: 8];
            1: cur[k*8 +: 8] = 8'(prev[k*8 +: 8] + $urandom_range(2) - 1);
            default: cur[k*8 +: 8] = 8'($urandom_range(255));
         endcase
      end
      push_request(prev, cur, frame_end, kind, group);
   endtask

   // driver: requests and response backpressure change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || request_taken) begin
         if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
            next_request = pending_requests.pop_front();
            req_ch.prev_byte0  <= next_request.prev[0];
            req_ch.prev_byte1  <= next_request.prev[1];
            req_ch.prev_byte2  <= next_request.prev[2];
            req_ch.prev_byte3  <= next_request.prev[3];
            req_ch.cur_byte0   <= next_request.cur[0];
            req_ch.cur_byte1   <= next_request.cur[1];
            req_ch.cur_byte2   <= next_request.cur[2];
            req_ch.cur_byte3   <= next_request.cur[3];
            req_ch.frame_end   <= next_request.frame_end;
            req_ch.frame_kind  <= next_request.kind;
            req_ch.group_start <= next_request.group_start;
            req_ch.valid       <= 1'b1;
            sent_count++;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 21);
   end

   // monitor: predict on request handshakes, check on response handshakes
   always @(posedge clock) begin
      request_taken = 1'b0;
      if (reset) begin
         frame_sum = '0;
         clear_group_best();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            request_taken = 1'b1;
            seen_request.prev = {req_ch.prev_byte3, req_ch.prev_byte2,
                                 req_ch.prev_byte1, req_ch.prev_byte0};
            seen_request.cur  = {req_ch.cur_byte3, req_ch.cur_byte2,
                                 req_ch.cur_byte1, req_ch.cur_byte0};
            seen_request.frame_end   = req_ch.frame_end;
            seen_request.kind        = frame_kind_type'(req_ch.frame_kind);
            seen_request.group_start = req_ch.group_start;
            predict_drop(seen_request);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_drops.size() == 0) begin
               report_mismatch($sformatf("unexpected drop response frame %0h",
                                         rsp_ch.drop_frame));
            end else begin
               want = expected_drops.pop_front();
               if (rsp_ch.drop_frame !== want.frame)
                  report_mismatch($sformatf("drop_frame %0h, want %0h",
                                            rsp_ch.drop_frame, want.frame));
               if (rsp_ch.drop_slot !== want.slot)
                  report_mismatch($sformatf("drop_slot %0d, want %0d",
                                            rsp_ch.drop_slot, want.slot));
               if (rsp_ch.drop_difference !== want.difference)
                  report_mismatch($sformatf("drop_difference %0h, want %0h",
                                            rsp_ch.drop_difference, want.difference));
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [GROUP_W-1:0] group_base;
      logic [GROUP_W-1:0] group;
      frame_kind_type     end_kind;
      frame_kind_type     kind;
      int                 spread;
      int                 len;
      int                 pick;

      reset = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.prev_byte0  = '0;
      req_ch.prev_byte1  = '0;
      req_ch.prev_byte2  = '0;
      req_ch.prev_byte3  = '0;
      req_ch.cur_byte0   = '0;
      req_ch.cur_byte1   = '0;
      req_ch.cur_byte2   = '0;
      req_ch.cur_byte3   = '0;
      req_ch.frame_end   = 1'b0;
      req_ch.frame_kind  = KIND_COMPARE;
      req_ch.group_start = '0;
      rsp_ch.ready       = 1'b0;

      // group at the top frame number: equal sums keep the earlier frame,
      // closing kind decides candidacy, past-end frames offer zero
      push_request(32'hffff_ffff, 32'h0000_0000, 1'b1, KIND_COMPARE, 24'hff_ffff);
      push_request(32'h0000_0000, 32'hffff_ffff, 1'b1, KIND_COMPARE, 24'hff_ffff);
      push_request(32'h0000_0005, 32'h0000_0000, 1'b0, KIND_COMPARE, 24'hff_ffff);
      push_request(32'h1234_5678, 32'h8765_4321, 1'b1, KIND_SKIP, 24'hff_ffff);
      push_request(32'hff00_ff00, 32'h00ff_00ff, 1'b0, KIND_COMPARE, 24'hff_ffff);
      push_request(32'h0000_0000, 32'h0000_0000, 1'b1, KIND_PAST_END, 24'hff_ffff);
      push_request(32'h1234_5678, 32'h8765_4321, 1'b1, KIND_PAST_END, 24'hff_ffff);

      // no candidate at all: the last frame is dropped by default, and only
      // the closing request's group number counts
      push_request(32'hffff_ffff, 32'h0000_0000, 1'b1, KIND_SKIP, 24'h00_0000);
      push_request(32'h0000_0000, 32'hffff_ffff, 1'b1, KIND_UNUSED, 24'h55_5555);
      push_request(32'ha5a5_a5a5, 32'h5a5a_5a5a, 1'b1, KIND_SKIP, 24'haa_aaaa);
      push_request(32'h0102_0304, 32'hf0e0_d0c0, 1'b1, KIND_UNUSED, 24'h00_0000);
      push_request(32'h8080_8080, 32'h7f7f_7f7f, 1'b1, KIND_SKIP, 24'hff_ffff);

      // falling sums with ignored requests inside frames, last frame wins
      push_request(32'hffff_ffff, 32'h0000_0000, 1'b1, KIND_COMPARE, 24'h00_0000);
      push_request(32'h0000_0000, 32'hffff_ffff, 1'b1, KIND_UNUSED, 24'h00_0000);
      push_request(32'h0a0a_0a0a, 32'h0000_0000, 1'b0, KIND_COMPARE, 24'h00_0000);
      push_request(32'hffff_ffff, 32'h0000_0000, 1'b0, KIND_SKIP, 24'h00_0000);
      push_request(32'h0000_0000, 32'h0f0f_0f0f, 1'b1, KIND_COMPARE, 24'h00_0000);
      push_request(32'h0000_0000, 32'hffff_ffff, 1'b0, KIND_PAST_END, 24'h00_0000);
      push_request(32'h8080_8080, 32'h7373_7373, 1'b1, KIND_COMPARE, 24'h00_0000);
      push_request(32'ha5a5_a5a5, 32'ha5a5_a5a5, 1'b1, KIND_COMPARE, 24'h00_0000);

      // random groups of five frames
      while (queued_count < 20 + RANDOM_REQUESTS) begin
         group_base = ($urandom_range(7) == 0) ? 24'hff_ffff - 24'($urandom_range(3))
                                               : 24'($urandom());
         spread = $urandom_range(2);
         for (int f = 0; f < GROUP_FRAMES; f++) begin
            pick = $urandom_range(99);
            if (pick < 60)
               end_kind = KIND_COMPARE;
            else if (pick < 75)
               end_kind = KIND_PAST_END;
            else if (pick < 90)
               end_kind = KIND_SKIP;
            else
               end_kind = KIND_UNUSED;
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 5) : $urandom_range(4, 1);
            for (int i = 0; i < len; i++) begin
               if (i == len - 1)
                  kind = end_kind;
               else if ($urandom_range(4) == 0)
                  kind = frame_kind_type'($urandom_range(3));
               else
                  kind = KIND_COMPARE;
               group = ($urandom_range(9) == 0) ? 24'($urandom()) : group_base;
               push_random_request(i == len - 1, kind, group, spread);
            end
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // drain requests, then responses, then a short tail for strays
      while (pending_requests.size() != 0 || req_ch.valid)
         @(negedge clock);
      while (expected_drops.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);

      if (mismatch_count == 0)
         $display("pulldown_duplicate_frame_picker_core test passed");
      else
         $display("pulldown_duplicate_frame_picker_core test failed");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("pulldown_duplicate_frame_picker_core test failed");
      $finish;
   end

endmodule

/* pulldown_duplicate_frame_picker_core.f */
hdl/pdfp_pkg.sv
hdl/pdfp_if.sv
hdl/pdfp_lane.sv
hdl/pdfp_merge.sv
hdl/pdfp_picker.sv
hdl/pulldown_duplicate_frame_picker_core.sv
hdl/pdfp_checker.sv
tb/sv/tb_pulldown_duplicate_frame_picker_core.sv
